>>> design/osfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and fixed-point constants for the observer
// state-feedback regulator. No dependencies.
package osfr_pkg;

  // Internal Q16 value widths
  localparam int Q_W    = 21;  // converted samples, angles, estimates, drive
  localparam int X1_W   = 27;  // motor speed
  localparam int RND_W  = 49;  // rounded product
  localparam int ACC_W  = 50;  // feedback / memory accumulator
  localparam int PROD_W = 64;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_GEV = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GEI = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAA = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GMS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OBS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MWV = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MWS = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MWA = 3'd7;

  localparam logic signed [31:0] RST_GEV = 32'sd85662610;
  localparam logic signed [31:0] RST_GEI = 32'sd21864356;
  localparam logic signed [31:0] RST_GAA = 32'sd4182494;
  localparam logic signed [31:0] RST_GMS = 32'sd11890;
  localparam logic signed [31:0] RST_OBS = 32'sd732919;
  localparam logic signed [31:0] RST_MWV = -32'sd712177;
  localparam logic signed [31:0] RST_MWS = 32'sd47486;
  localparam logic signed [31:0] RST_MWA = 32'sd1412;

  // Conversion constants, Q24 scales and Q16 offsets
  localparam logic signed [31:0] C_TACHO      = 32'sd585633890;
  localparam logic signed [31:0] C_STICK_ZERO = 32'sd43257;
  localparam logic signed [31:0] C_ARM_ZERO   = 32'sd96402;
  localparam logic signed [31:0] C_STICK_SCL  = 32'sd12305501;
  localparam logic signed [31:0] C_ARM_SCL    = 32'sd11433673;
  localparam logic signed [31:0] C_INV_EST    = 32'sd2613705;
  localparam logic signed [31:0] C_ARM_WGT    = 32'sd24106846;

  // Q16 limits
  localparam logic signed [Q_W-1:0] DEAD_ZONE       = 21'sd104858;
  localparam logic signed [Q_W-1:0] DEAD_ZONE_NEG   = -21'sd104858;
  localparam logic signed [Q_W-1:0] DRIVE_LIMIT     = 21'sd327680;
  localparam logic signed [Q_W-1:0] DRIVE_LIMIT_NEG = -21'sd327680;
  localparam logic signed [Q_W-1:0] ARM_LIMIT       = 21'sd117965;
  localparam logic signed [Q_W-1:0] ARM_LIMIT_NEG   = -21'sd117965;

  typedef struct packed {
    logic signed [31:0] gev;
    logic signed [31:0] gei;
    logic signed [31:0] gaa;
    logic signed [31:0] gms;
    logic signed [31:0] obs;
    logic signed [31:0] mwv;
    logic signed [31:0] mws;
    logic signed [31:0] mwa;
  } gains_t;

  // Multiplier operand pair
  typedef enum logic [3:0] {
    MUL_NONE, MUL_TACHO, MUL_ARM, MUL_STICK, MUL_ARMW, MUL_INV, MUL_OBS,
    MUL_GEV, MUL_GEI, MUL_GAA, MUL_GMS, MUL_MWV, MUL_MWS, MUL_MWA
  } mul_sel_t;

  // Where the rounded product goes
  typedef enum logic [3:0] {
    AP_NONE, AP_X1, AP_ARM, AP_EST_SET, AP_EST_ADD, AP_X1E, AP_X2E,
    AP_ACC_SET, AP_ACC_ADD
  } apply_t;

  typedef enum logic [1:0] {
    DRV_HOLD, DRV_CALC, DRV_ZERO
  } drive_op_t;

  typedef struct packed {
    logic      load;
    mul_sel_t  mul;
    apply_t    apply;
    drive_op_t drive;
    logic      mem_wr;
    logic      publish;
  } dp_cmd_t;

  typedef struct packed {
    logic arm_over;
  } dp_status_t;

endpackage

>>> design/osfr_cfg.sv
`timescale 1ns / 1ps
// APB-style register bank holding the eight feedback and observer gains.
// Depends on osfr_pkg.
module osfr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [osfr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output osfr_pkg::gains_t                   gains
);
  import osfr_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.gev <= RST_GEV;
      gains.gei <= RST_GEI;
      gains.gaa <= RST_GAA;
      gains.gms <= RST_GMS;
      gains.obs <= RST_OBS;
      gains.mwv <= RST_MWV;
      gains.mws <= RST_MWS;
      gains.mwa <= RST_MWA;
    end else if (wr_en) begin
      unique case (idx)
        REG_GEV: gains.gev <= pwdata;
        REG_GEI: gains.gei <= pwdata;
        REG_GAA: gains.gaa <= pwdata;
        REG_GMS: gains.gms <= pwdata;
        REG_OBS: gains.obs <= pwdata;
        REG_MWV: gains.mwv <= pwdata;
        REG_MWS: gains.mws <= pwdata;
        REG_MWA: gains.mwa <= pwdata;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_GEV: prdata = gains.gev;
      REG_GEI: prdata = gains.gei;
      REG_GAA: prdata = gains.gaa;
      REG_GMS: prdata = gains.gms;
      REG_OBS: prdata = gains.obs;
      REG_MWV: prdata = gains.mwv;
      REG_MWS: prdata = gains.mws;
      REG_MWA: prdata = gains.mwa;
    endcase
  end

endmodule

>>> design/osfr_dp.sv
`timescale 1ns / 1ps
// Datapath: sample conversion, one shared 32x32 multiplier with rounding,
// state registers, observer memory, drive shaping. Depends on osfr_pkg.
module osfr_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  osfr_pkg::dp_cmd_t             cmd,
  output osfr_pkg::dp_status_t          status,
  input  osfr_pkg::gains_t              gains,
  input  logic signed [SAMPLE_BITS-1:0] tacho_volts,
  input  logic signed [SAMPLE_BITS-1:0] arm_volts,
  input  logic signed [SAMPLE_BITS-1:0] stick_volts,
  output logic signed [SAMPLE_BITS-1:0] drive_volts
);
  import osfr_pkg::*;

  localparam int FRAC_BITS = SAMPLE_BITS - 4;

  localparam logic signed [ACC_W-1:0] KNEE_POS = ACC_W'(222822);
  localparam logic signed [ACC_W-1:0] KNEE_NEG = -ACC_W'(222822);

  logic signed [SAMPLE_BITS-1:0] raw [3];
  logic signed [Q_W-1:0]         q16 [3];

  logic signed [Q_W-1:0]    vt, va, vs;
  logic signed [X1_W-1:0]   x1;
  logic signed [Q_W-1:0]    arm, est, x1e;
  logic signed [31:0]       x2e, mem;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       a_op, b_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  r24, r16;
  logic signed [ACC_W-1:0]  x2e_sum;
  logic signed [Q_W-1:0]    acc_lo, u_calc, drive_work;
  logic signed [SAMPLE_BITS-1:0] drive_conv;

  // clamp to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic fits;
    fits = (x[ACC_W-1:31] == {(ACC_W-31){x[31]}});
    if (fits)
      sat32 = x[31:0];
    else if (x[ACC_W-1])
      sat32 = 32'sh8000_0000;
    else
      sat32 = 32'sh7fff_ffff;
  endfunction

  // sample format to Q16
  assign raw[0] = tacho_volts;
  assign raw[1] = arm_volts;
  assign raw[2] = stick_volts;

  for (genvar i = 0; i < 3; i++) begin : g_in
    if (FRAC_BITS <= 16) begin : g_up
      assign q16[i] = Q_W'(raw[i]) <<< (16 - FRAC_BITS);
    end else begin : g_dn
      localparam int K = FRAC_BITS - 16;
      assign q16[i] = Q_W'(raw[i] >>> K) + Q_W'({1'b0, raw[i][K-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vt <= q16[0];
      va <= q16[1];
      vs <= q16[2];
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul)
      MUL_TACHO: begin a_op = C_TACHO;     b_op = 32'(vt);                    end
      MUL_ARM:   begin a_op = C_ARM_SCL;   b_op = 32'(va) - C_ARM_ZERO;       end
      MUL_STICK: begin a_op = C_STICK_SCL; b_op = 32'(vs) - C_STICK_ZERO;     end
      MUL_ARMW:  begin a_op = C_ARM_WGT;   b_op = 32'(arm);                   end
      MUL_INV:   begin a_op = C_INV_EST;   b_op = 32'(est);                   end
      MUL_OBS:   begin a_op = gains.obs;   b_op = 32'(x1e);                   end
      MUL_GEV:   begin a_op = gains.gev;   b_op = 32'(x1e);                   end
      MUL_GEI:   begin a_op = gains.gei;   b_op = x2e;                        end
      MUL_GAA:   begin a_op = gains.gaa;   b_op = 32'(arm);                   end
      MUL_GMS:   begin a_op = gains.gms;   b_op = 32'(x1);                    end
      MUL_MWV:   begin a_op = gains.mwv;   b_op = 32'(x1e);                   end
      MUL_MWS:   begin a_op = gains.mws;   b_op = x2e;                        end
      MUL_MWA:   begin a_op = gains.mwa;   b_op = 32'(arm);                   end
      default:   begin a_op = '0;          b_op = '0;                         end
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE)
      prod <= a_op * b_op;
  end

  // round half up: floor shift plus the last bit shifted out
  assign r24 = RND_W'(prod >>> 24) + RND_W'({1'b0, prod[23]});
  assign r16 = RND_W'(prod >>> 16) + RND_W'({1'b0, prod[15]});
  assign x2e_sum = ACC_W'(mem) + ACC_W'(r16);

  // write back of the rounded product
  always_ff @(posedge clk) begin
    unique case (cmd.apply)
      AP_X1:      x1  <= X1_W'(-r24);
      AP_ARM:     arm <= Q_W'(r24);
      AP_EST_SET: est <= Q_W'(r24);
      AP_EST_ADD: est <= est + Q_W'(r24);
      AP_X1E:     x1e <= Q_W'(-r24);
      AP_X2E:     x2e <= sat32(x2e_sum);
      AP_ACC_SET: acc <= ACC_W'(r16);
      AP_ACC_ADD: acc <= acc + ACC_W'(r16);
      default: ;
    endcase
  end

  // observer memory
  always_ff @(posedge clk) begin
    if (rst)
      mem <= '0;
    else if (cmd.mem_wr)
      mem <= sat32(acc);
  end

  assign status.arm_over = (arm > ARM_LIMIT) || (arm < ARM_LIMIT_NEG);

  // drive = -acc with dead-zone step and clamp, decided on acc directly
  assign acc_lo = Q_W'(acc);

  always_comb begin
    priority if (acc == '0)
      u_calc = '0;
    else if (acc < KNEE_NEG)
      u_calc = DRIVE_LIMIT;
    else if (acc[ACC_W-1])
      u_calc = DEAD_ZONE - acc_lo;
    else if (acc > KNEE_POS)
      u_calc = DRIVE_LIMIT_NEG;
    else
      u_calc = DEAD_ZONE_NEG - acc_lo;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.drive)
      DRV_CALC: drive_work <= u_calc;
      DRV_ZERO: drive_work <= '0;
      default: ;
    endcase
  end

  // Q16 back to sample format
  if (FRAC_BITS >= 16) begin : g_out_up
    assign drive_conv = SAMPLE_BITS'(drive_work) <<< (FRAC_BITS - 16);
  end else begin : g_out_dn
    localparam int K2 = 16 - FRAC_BITS;
    assign drive_conv = SAMPLE_BITS'(drive_work >>> K2)
                      + SAMPLE_BITS'({1'b0, drive_work[K2-1]});
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish)
      drive_volts <= drive_conv;
  end

  a_mem_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.mem_wr |=> $stable(mem))
    else $error("observer memory changed without a write command");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.drive == DRV_CALC) |=>
      (drive_work <= DRIVE_LIMIT) && (drive_work >= DRIVE_LIMIT_NEG))
    else $error("shaped drive outside the clamp range");

endmodule

>>> design/osfr_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the shared multiplier through the product list,
// owns the handshakes and the emergency-stop latch. Depends on osfr_pkg.
module osfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 emergency_stop,
  output osfr_pkg::dp_cmd_t    cmd,
  input  osfr_pkg::dp_status_t status
);
  import osfr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [4:0] LAST_STEP  = 5'd16;
  localparam logic [4:0] CHECK_STEP = 5'd3;

  logic [1:0] state, state_next;
  logic [4:0] step, step_next;
  logic       halted, halted_next;
  logic       out_valid_next, stop_next;
  logic       accept, slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    step_next      = step;
    halted_next    = halted;
    out_valid_next = out_valid && out_stall;
    stop_next      = emergency_stop;
    cmd            = '{load: 1'b0, mul: MUL_NONE, apply: AP_NONE,
                       drive: DRV_HOLD, mem_wr: 1'b0, publish: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
          step_next  = '0;
        end
      end

      ST_RUN: begin
        step_next = step + 5'd1;
        if (step == LAST_STEP)
          state_next = ST_DONE;
        // product issued in one step lands in the next
        unique case (step)
          5'd0:  cmd.mul = MUL_TACHO;
          5'd1:  begin cmd.apply = AP_X1;  cmd.mul = MUL_ARM; end
          5'd2:  begin cmd.apply = AP_ARM; cmd.mul = MUL_STICK; end
          CHECK_STEP: begin
            if (halted || status.arm_over) begin
              halted_next = 1'b1;
              cmd.drive   = DRV_ZERO;
              state_next  = ST_DONE;
            end else begin
              cmd.apply = AP_EST_SET;
              cmd.mul   = MUL_ARMW;
            end
          end
          5'd4:  cmd.apply = AP_EST_ADD;
          5'd5:  cmd.mul   = MUL_INV;
          5'd6:  cmd.apply = AP_X1E;
          5'd7:  cmd.mul   = MUL_OBS;
          5'd8:  begin cmd.apply = AP_X2E;     cmd.mul = MUL_GEV; end
          5'd9:  begin cmd.apply = AP_ACC_SET; cmd.mul = MUL_GEI; end
          5'd10: begin cmd.apply = AP_ACC_ADD; cmd.mul = MUL_GAA; end
          5'd11: begin cmd.apply = AP_ACC_ADD; cmd.mul = MUL_GMS; end
          5'd12: begin cmd.apply = AP_ACC_ADD; cmd.mul = MUL_MWV; end
          5'd13: begin
            cmd.drive = DRV_CALC;
            cmd.apply = AP_ACC_SET;
            cmd.mul   = MUL_MWS;
          end
          5'd14: begin cmd.apply = AP_ACC_ADD; cmd.mul = MUL_MWA; end
          5'd15: cmd.apply  = AP_ACC_ADD;
          5'd16: cmd.mem_wr = 1'b1;
          default: ;
        endcase
      end

      ST_DONE: begin
        if (slot_free) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          stop_next      = halted;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= '0;
      halted         <= 1'b0;
      out_valid      <= 1'b0;
      emergency_stop <= 1'b0;
    end else begin
      state          <= state_next;
      step           <= step_next;
      halted         <= halted_next;
      out_valid      <= out_valid_next;
      emergency_stop <= stop_next;
    end
  end

  a_halt_latched: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("emergency stop latch released without reset");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= LAST_STEP))
    else $error("sequencer step past the end of the product list");

  a_mem_only_running: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> !halted && (state == ST_RUN))
    else $error("observer memory written while stopped");

endmodule

>>> design/observer_state_feedback_regulator.sv
`timescale 1ns / 1ps
// Observer state-feedback regulator, top level. Depends on osfr_pkg,
// osfr_cfg, osfr_dp and osfr_ctrl.
// The input beat is taken only while idle; the result is offered once the
// sequence ends, or early at the arm check once the emergency stop is latched
// or trips on that beat. A new beat is not taken until the result is offered,
// as the single shared 32x32 multiplier works through 13 products in sequence.
// Reset (synchronous): gains to defaults, observer memory 0, stop cleared.
module observer_state_feedback_regulator #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       tacho_volts,
  input  logic signed [SAMPLE_BITS-1:0]       arm_volts,
  input  logic signed [SAMPLE_BITS-1:0]       stick_volts,
  // drive channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       drive_volts,
  output logic                                emergency_stop,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [osfr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import osfr_pkg::*;

  gains_t     gains;
  dp_cmd_t    cmd;
  dp_status_t status;

  osfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  osfr_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .gains       (gains),
    .tacho_volts (tacho_volts),
    .arm_volts   (arm_volts),
    .stick_volts (stick_volts),
    .drive_volts (drive_volts)
  );

  osfr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .emergency_stop (emergency_stop),
    .cmd            (cmd),
    .status         (status)
  );

  a_stop_zero_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && emergency_stop |-> (drive_volts == '0))
    else $error("drive nonzero on a stopped beat");

endmodule
